// ===== sv/tlpq_pkg.sv =====
// Package: shared types and codes for the three-level priority queue.
`default_nettype none
package tlpq_pkg;

    // Request modes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BADPR = 2'd3;

    // Priority code that is not a valid level
    localparam logic [1:0] PR_NONE = 2'd0;

    // Number of priority levels
    localparam int NUM_LEVELS = 3;

    typedef struct packed {
        logic        mode;
        logic [1:0]  priority_req;
        logic [63:0] id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  out_priority;
        logic [63:0] out_id;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;
        logic exec;
        logic load_rd;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pop_hit;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/three_level_priority_queue_top.sv =====
// Top level of the three-level priority queue: controller plus datapath.
//
// Usage: a request item (push or pop) enters on the req channel when
// req_valid is high and req_stall is low. Each request yields exactly one
// result item on the rsp channel: status, and for a successful pop the
// priority and id of the head entry. Priority 1 is served first; within a
// level entries leave first in, first out. The queue holds DEPTH entries.
// A push or failed request passes through S_EXEC to S_OUT; a successful pop
// also passes S_READ, for the registered tag memory read.
// The block takes one request at a time: no new request is accepted until
// the result item of the last one has been accepted.
// Reset empties the queue at once (level counts and pointers cleared).
// While rsp_stall is high the result holds steady and no new request is
// taken until the result item has been accepted.
`default_nettype none
module three_level_priority_queue_top
    import tlpq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    cmd_t       cmd;
    dp_status_t dp_status;

    tlpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    tlpq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .dp_status (dp_status),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ===== sv/tlpq_ctrl.sv =====
// Controller state machine: sequences request capture, execution, read and result.
`default_nettype none
module tlpq_ctrl
    import tlpq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    input  wire dp_status_t dp_status,
    output cmd_t            cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.load_req = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_rd  = 1'b0;
        req_stall    = 1'b1;
        rsp_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall    = 1'b0;
                cmd.load_req = req_valid;
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                // a successful pop goes through S_READ for the tag read
                state_next = dp_status.pop_hit ? S_READ : S_OUT;
            end
            S_READ:
            begin
                cmd.load_rd = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/tlpq_dpath.sv =====
// Datapath: per-level FIFO pointers, counts, tag memory and result register.
`default_nettype none
module tlpq_dpath
    import tlpq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire req_t       req,
    input  wire cmd_t       cmd,
    output dp_status_t      dp_status,
    output rsp_t            rsp
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MEM_WORDS = 1 << (PW + 2);

    req_t          req_reg;
    rsp_t          rsp_reg;
    logic [PW-1:0] head_reg [NUM_LEVELS];
    logic [PW-1:0] head_next [NUM_LEVELS];
    logic [PW-1:0] tail_reg [NUM_LEVELS];
    logic [PW-1:0] tail_next [NUM_LEVELS];
    logic [CW-1:0] cnt_reg [NUM_LEVELS];
    logic [CW-1:0] cnt_next [NUM_LEVELS];
    logic [CW-1:0] total_reg;
    logic [CW-1:0] total_next;
    logic [63:0]   mem [MEM_WORDS];
    logic [63:0]   rd_data_reg;
    logic [1:0]    pop_pr_reg;

    logic [1:0]    push_lvl;
    logic [1:0]    pop_lvl;
    logic [PW-1:0] push_ptr;
    logic [PW-1:0] pop_ptr;
    logic          is_full;
    logic          is_empty;
    logic          push_ok;
    logic          pop_ok;
    logic [1:0]    exec_status;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
    end

    // Decision logic
    always_comb
    begin
        push_lvl = req_reg.priority_req - 2'd1;
        priority if (cnt_reg[0] != '0)
        begin
            pop_lvl = 2'd0;
        end
        else if (cnt_reg[1] != '0)
        begin
            pop_lvl = 2'd1;
        end
        else
        begin
            pop_lvl = 2'd2;
        end
        unique case (push_lvl)
            2'd0:    push_ptr = tail_reg[0];
            2'd1:    push_ptr = tail_reg[1];
            default: push_ptr = tail_reg[2];
        endcase
        unique case (pop_lvl)
            2'd0:    pop_ptr = head_reg[0];
            2'd1:    pop_ptr = head_reg[1];
            default: pop_ptr = head_reg[2];
        endcase
        is_full  = (total_reg == CW'(DEPTH));
        is_empty = (total_reg == '0);
        push_ok  = cmd.exec && (req_reg.mode == MODE_PUSH) && !is_full
                   && (req_reg.priority_req != PR_NONE);
        pop_ok   = cmd.exec && (req_reg.mode == MODE_POP) && !is_empty;
        // full test comes before the priority check
        priority if (req_reg.mode == MODE_PUSH && is_full)
        begin
            exec_status = ST_FULL;
        end
        else if (req_reg.mode == MODE_PUSH && req_reg.priority_req == PR_NONE)
        begin
            exec_status = ST_BADPR;
        end
        else if (req_reg.mode == MODE_POP && is_empty)
        begin
            exec_status = ST_EMPTY;
        end
        else
        begin
            exec_status = ST_DONE;
        end
        dp_status.pop_hit = (req_reg.mode == MODE_POP) && !is_empty;
    end

    // Pointer and count update
    always_comb
    begin
        total_next = total_reg;
        if (push_ok)
        begin
            total_next = total_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            total_next = total_reg - 1'b1;
        end
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            head_next[l] = head_reg[l];
            tail_next[l] = tail_reg[l];
            cnt_next[l]  = cnt_reg[l];
            if (push_ok && push_lvl == 2'(l))
            begin
                tail_next[l] = (tail_reg[l] == PW'(DEPTH - 1)) ? '0 : tail_reg[l] + 1'b1;
                cnt_next[l]  = cnt_reg[l] + 1'b1;
            end
            if (pop_ok && pop_lvl == 2'(l))
            begin
                head_next[l] = (head_reg[l] == PW'(DEPTH - 1)) ? '0 : head_reg[l] + 1'b1;
                cnt_next[l]  = cnt_reg[l] - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end
        else
        begin
            total_reg <= total_next;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= head_next[l];
                tail_reg[l] <= tail_next[l];
                cnt_reg[l]  <= cnt_next[l];
            end
        end
    end

    // Tag memory: one region per level, registered read
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[{push_lvl, push_ptr}] <= req_reg.id;
        end
        if (pop_ok)
        begin
            rd_data_reg <= mem[{pop_lvl, pop_ptr}];
            pop_pr_reg  <= pop_lvl + 2'd1;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec && !dp_status.pop_hit)
        begin
            rsp_reg.status       <= exec_status;
            rsp_reg.out_priority <= PR_NONE;
            rsp_reg.out_id       <= '0;
        end
        else if (cmd.load_rd)
        begin
            rsp_reg.status       <= ST_DONE;
            rsp_reg.out_priority <= pop_pr_reg;
            rsp_reg.out_id       <= rd_data_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the three-level priority queue: shadow queue, random traffic, result checks.
`timescale 1ns / 100ps
module tb_top;
    import tlpq_pkg::*;

    localparam int          QDEPTH          = 128;
    localparam int          CLK_PERIOD      = 8;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    // Shadow of the queue contents plus the results still owed by the block
    class prio_queue_shadow;
        typedef struct packed {
            logic [1:0]  level;
            logic [63:0] tag;
        } slot_t;

        slot_t shadow_slots[$];
        rsp_t  due_rsps[$];
        int    depth;
        int    mismatches;

        function new(int d);
            depth      = d;
            mismatches = 0;
        endfunction

        function int live_count();
            return shadow_slots.size();
        endfunction

        function int pending();
            return due_rsps.size();
        endfunction

        // Apply one accepted request and queue the result it must produce
        function void take_request(req_t r);
            rsp_t  e;
            slot_t s;
            int    pos;
            e = '0;
            if (r.mode == MODE_PUSH) begin
                if (shadow_slots.size() >= depth)
                    e.status = ST_FULL;
                else if (r.priority_req == PR_NONE)
                    e.status = ST_BADPR;
                else begin
                    // new entry goes behind every entry of equal or better level
                    pos = shadow_slots.size();
                    while (pos > 0 && shadow_slots[pos-1].level > r.priority_req)
                        pos--;
                    s.level = r.priority_req;
                    s.tag   = r.id;
                    shadow_slots.insert(pos, s);
                    e.status = ST_DONE;
                end
            end
            else if (shadow_slots.size() == 0)
                e.status = ST_EMPTY;
            else begin
                e.status       = ST_DONE;
                e.out_priority = shadow_slots[0].level;
                e.out_id       = shadow_slots[0].tag;
                void'(shadow_slots.pop_front());
            end
            due_rsps.push_back(e);
        endfunction

        // Compare one accepted result against the oldest owed result
        function void check_rsp(rsp_t a);
            rsp_t e;
            if (due_rsps.size() == 0) begin
                $error("unexpected result: status %0d priority %0d id %h",
                       a.status, a.out_priority, a.out_id);
                mismatches++;
                return;
            end
            e = due_rsps.pop_front();
            if (a.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, a.status);
                mismatches++;
            end
            if (a.out_priority !== e.out_priority) begin
                $error("out_priority: expected %0d, got %0d", e.out_priority, a.out_priority);
                mismatches++;
            end
            if (a.out_id !== e.out_id) begin
                $error("out_id: expected %h, got %h", e.out_id, a.out_id);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    bit hold_off_req = 1'b0;

    prio_queue_shadow shadow = new(QDEPTH);

    three_level_priority_queue_top #(
        .DEPTH(QDEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic req_t make_req(logic m, logic [1:0] pr, logic [63:0] tag);
        req_t r;
        r.mode         = m;
        r.priority_req = pr;
        r.id           = tag;
        return r;
    endfunction

    // Random request; pops carry random ignored fields too
    function automatic req_t random_request(int push_pct);
        req_t r;
        int   sel;
        r.mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
        r.priority_req = ($urandom_range(0, 9) == 0) ? PR_NONE : 2'($urandom_range(1, 3));
        sel = $urandom_range(0, 15);
        if (sel == 0)
            r.id = '0;
        else if (sel == 1)
            r.id = '1;
        else
            r.id = {$urandom, $urandom};
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one item and hold it until accepted; valid stays high afterwards
    task automatic send_request(input req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        shadow.take_request(r);
    endtask

    task automatic sender_gap(input int n);
        if (n > 0) begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Sender pauses until every owed result has come back
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (shadow.pending() != 0);
    endtask

    task automatic run_phase(input int n, input int push_pct, input bit with_gaps);
        for (int k = 0; k < n; k++) begin
            send_request(random_request(push_pct));
            if (with_gaps)
                sender_gap(pick_gap());
        end
    endtask

    // Result side: random stalls, quiet stretches, one long hold-off on request
    initial begin : receiver
        int stall_left;
        int quiet_left;
        int r;
        stall_left = 0;
        quiet_left = 0;
        rsp_stall  = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                shadow.check_rsp(rsp);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
                quiet_left   = 0;
            end
            if (stall_left == 0 && quiet_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    quiet_left = $urandom_range(20, 80);
                else if (r >= 65 && r < 95)
                    stall_left = $urandom_range(1, 3);
                else if (r >= 95)
                    stall_left = $urandom_range(10, 40);
            end
            if (stall_left > 0) begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else begin
                rsp_stall <= 1'b0;
                if (quiet_left > 0)
                    quiet_left--;
            end
        end
    end

    // Run length guard
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, bad level, all levels with extreme tags, ordering
        send_request(make_req(MODE_POP,  2'd3,    '1));
        send_request(make_req(MODE_PUSH, PR_NONE, '1));
        send_request(make_req(MODE_PUSH, 2'd3,    '0));
        send_request(make_req(MODE_PUSH, 2'd3,    '1));
        send_request(make_req(MODE_PUSH, 2'd2,    64'h0123_4567_89ab_cdef));
        send_request(make_req(MODE_PUSH, 2'd1,    64'hffff_ffff_ffff_fffe));
        send_request(make_req(MODE_PUSH, 2'd2,    64'h8000_0000_0000_0001));
        send_request(make_req(MODE_PUSH, 2'd1,    64'h0000_0000_0000_0001));
        send_request(make_req(MODE_PUSH, PR_NONE, 64'h5555_aaaa_5555_aaaa));
        send_request(make_req(MODE_POP,  PR_NONE, '0));
        send_request(make_req(MODE_POP,  2'd1,    '1));
        send_request(make_req(MODE_POP,  2'd2,    64'hdead_beef_0000_0000));
        send_request(make_req(MODE_PUSH, 2'd1,    64'h7fff_ffff_ffff_ffff));
        send_request(make_req(MODE_POP,  2'd3,    '0));
        send_request(make_req(MODE_POP,  PR_NONE, '0));
        send_request(make_req(MODE_POP,  PR_NONE, '0));
        send_request(make_req(MODE_POP,  PR_NONE, '0));
        send_request(make_req(MODE_POP,  PR_NONE, '0));
        wait_for_results();

        // random traffic: mixed, fill past full, drain past empty
        run_phase(150, 50, 1'b1);
        run_phase(220, 92, 1'b1);
        wait_for_results();
        run_phase(200, 8, 1'b1);

        // receiver holds off while items keep coming back to back
        hold_off_req = 1'b1;
        run_phase(150, 55, 1'b0);
        run_phase(200, 90, 1'b0);
        run_phase(130, 15, 1'b1);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tlpq_pkg.sv
sv/tlpq_ctrl.sv
sv/tlpq_dpath.sv
sv/three_level_priority_queue_top.sv
tb/tb_top.sv
